/* rtl/pps_pkg.sv */
// shared types and constants of the pure pursuit steering block
package pps_pkg;

	// fixed field widths
	localparam int LA_W    = 24;
	localparam int WB_W    = 21;
	localparam int LIMIT_W = 14;
	localparam int SW_W    = 16;
	localparam int STEER_W = 15;
	localparam int SIN_W   = 17;

	// shared multiplier operand and product widths
	localparam int MA_W = 22;
	localparam int MB_W = 17;
	localparam int PW   = MA_W + MB_W;

	// angle accumulator, radians Q.16
	localparam int ZW = 21;

	localparam logic signed [ZW-1:0] PI_Z      = 21'sd205887;
	localparam logic signed [ZW-1:0] HALF_PI_Z = 21'sd102944;
	localparam logic signed [ZW-1:0] TWO_PI_Z  = 21'sd411775;

	// 1/K of the cordic gain, Q30
	localparam int CORDIC_GAIN_INV = 652032874;

	// normalize thresholds as powers of two
	localparam int NORM_HI_EXP = 46;
	localparam int NORM_LO_EXP = 38;
	localparam int NORM_COARSE = 8;

	// arctangent table, radians Q.16
	localparam int TAB_LEN = 24;
	localparam int TIW     = 5;
	localparam logic [15:0] ATAN_TAB [TAB_LEN] = '{
		16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
		16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2,
		16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
	};

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_LOOKAHEAD   = 2'd0,
		REG_WHEEL_BASE  = 2'd1,
		REG_STEER_LIMIT = 2'd2,
		REG_SMOOTHING   = 2'd3
	} reg_idx_t;

	localparam logic [LA_W-1:0]    LA_RESET    = 24'd983040;
	localparam logic [WB_W-1:0]    WB_RESET    = 21'd176947;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd4260;
	localparam logic [SW_W-1:0]    SW_RESET    = 16'd16384;

	// sequencer states
	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_NORM   = 12'b0000_0000_0010,
		ST_ROT    = 12'b0000_0000_0100,
		ST_ALPHA  = 12'b0000_0000_1000,
		ST_WRAP   = 12'b0000_0001_0000,
		ST_SINOUT = 12'b0000_0010_0000,
		ST_MULS   = 12'b0000_0100_0000,
		ST_LOAD2  = 12'b0000_1000_0000,
		ST_CLAMP  = 12'b0001_0000_0000,
		ST_MULW   = 12'b0010_0000_0000,
		ST_MULL   = 12'b0100_0000_0000,
		ST_BLEND  = 12'b1000_0000_0000
	} state_t;

	// which cordic pass is running
	typedef enum logic [1:0] {
		PASS_BEARING = 2'd0,
		PASS_SINE    = 2'd1,
		PASS_STEER   = 2'd2
	} pass_t;

endpackage

/* rtl/pure_pursuit_steering.sv */
// pure pursuit steering controller on one shared cordic datapath
//
// channel   dir  handshake                       payload
// cfg       in   cfg_valid / cfg_ready           cfg_index, cfg_data
// s_axis    in   s_axis_tvalid / s_axis_tready   s_axis_tdata, s_axis_tuser
// m_axis    out  m_axis_tvalid / m_axis_tready   m_axis_tdata
//
// one input transaction runs the normalize shifts of the two atan2 passes, the alpha wrap
// and the rotator steps on the single cordic rotator, which runs bearing atan2, sine and
// steering atan2 in turn
// an input transaction with pose or path missing is taken in idle and gives no result
// the result sits in the output register; the next item computes meanwhile and
// waits in the blend step only while that result is still not taken
// arst_n clears the sequencer, output valid and the last steering, and sets the registers to their reset values
// cfg_ready is always high; the user must write registers between items, the block does not enforce it
module pure_pursuit_steering #(
	parameter int POSITION_BITS = 32,
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STEPS  = 16
) (
	input  logic clk,
	input  logic arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,

	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// vehicle_x, vehicle_y, vehicle_yaw, target_x, target_y, zero fill
	input  logic [((4*POSITION_BITS+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	// vehicle_present, path_present
	input  logic [1:0] s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// steering_angle, zero fill
	output logic [15:0] m_axis_tdata
);

	localparam int ZW  = pps_pkg::ZW;
	localparam int PW  = pps_pkg::PW;
	localparam int CW  = ((POSITION_BITS + 1 > pps_pkg::NORM_HI_EXP + 1) ?
		POSITION_BITS + 1 : pps_pkg::NORM_HI_EXP + 1) + 4;
	localparam int IW  = $clog2(CORDIC_STEPS);

	// field offsets inside tdata
	localparam int VY_LO  = POSITION_BITS;
	localparam int YAW_LO = 2 * POSITION_BITS;
	localparam int TX_LO  = 2 * POSITION_BITS + ANGLE_BITS;
	localparam int TY_LO  = 3 * POSITION_BITS + ANGLE_BITS;

	// yaw to Q.16: shift left, or round and shift right for fine formats
	localparam int YAW_SH = 16 - (ANGLE_BITS - 3);
	localparam int YAW_L  = (YAW_SH > 0) ? YAW_SH : 0;
	localparam int YAW_R  = (YAW_SH < 0) ? -YAW_SH : 0;
	localparam logic signed [31:0] YAW_RND = 32'((1 << YAW_R) >> 1);

	localparam logic [CW-1:0] NORM_HI = CW'(1) << pps_pkg::NORM_HI_EXP;
	localparam logic [CW-1:0] NORM_LO = CW'(1) << pps_pkg::NORM_LO_EXP;
	localparam logic signed [CW-1:0] GAIN_INV = CW'(pps_pkg::CORDIC_GAIN_INV);
	localparam logic signed [CW-1:0] SIN_HALF = CW'(16384);
	localparam logic signed [CW-1:0] SIN_MAX  = CW'(32768);
	localparam logic signed [PW-1:0] RES_HALF = PW'(16384);
	localparam logic signed [PW-1:0] RES_MAX  = PW'(16383);
	localparam logic signed [PW-1:0] RES_MIN  = -PW'(16384);

	// configuration registers
	logic [pps_pkg::LA_W-1:0]    la_q;
	logic [pps_pkg::WB_W-1:0]    wb_q;
	logic [pps_pkg::LIMIT_W-1:0] lim_q;
	logic [pps_pkg::SW_W-1:0]    sw_q;

	// control
	pps_pkg::state_t state_q, state_n;
	pps_pkg::pass_t  pass_q;
	logic [IW-1:0]   iter_q;
	logic            out_valid_q;
	logic signed [pps_pkg::STEER_W-1:0] last_q;

	// datapath
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q, yaw_q;
	logic signed [pps_pkg::SIN_W-1:0]   s_q;
	logic signed [pps_pkg::STEER_W-1:0] st_q;
	logic signed [PW-1:0] prod_q, acc_q;

	logic in_take, both_present, out_load, last_iter, cw, is_zero, both_lo, both_hi;
	logic [CW-1:0] mx, my;
	logic signed [CW-1:0] xs, ys, dx, dy, sv;
	logic signed [ZW-1:0] tab, stw, limz, stc, stn, fold;
	logic signed [31:0] yaw_w;
	logic [pps_pkg::TIW-1:0] tab_idx;
	logic [16:0] w_sat, w_comp;
	logic signed [pps_pkg::MA_W-1:0] mul_a;
	logic signed [pps_pkg::MB_W-1:0] mul_b;
	logic signed [PW-1:0] prod_n, sum, rnd;
	logic signed [pps_pkg::SIN_W-1:0]   s_n;
	logic signed [pps_pkg::STEER_W-1:0] res_n;
	pps_pkg::state_t atan_done;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == pps_pkg::ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	// the last steering is the result register
	assign m_axis_tdata  = {1'b0, last_q};

	assign in_take      = s_axis_tvalid && s_axis_tready;
	assign both_present = s_axis_tuser[0] && s_axis_tuser[1];
	assign out_load     = (state_q == pps_pkg::ST_BLEND) && (!out_valid_q || m_axis_tready);

	// input differences, sign extended to the rotator width
	always_comb begin
		dx = $signed({{(CW-POSITION_BITS){s_axis_tdata[TX_LO+POSITION_BITS-1]}},
			s_axis_tdata[TX_LO +: POSITION_BITS]})
			- $signed({{(CW-POSITION_BITS){s_axis_tdata[POSITION_BITS-1]}},
			s_axis_tdata[0 +: POSITION_BITS]});
		dy = $signed({{(CW-POSITION_BITS){s_axis_tdata[TY_LO+POSITION_BITS-1]}},
			s_axis_tdata[TY_LO +: POSITION_BITS]})
			- $signed({{(CW-POSITION_BITS){s_axis_tdata[VY_LO+POSITION_BITS-1]}},
			s_axis_tdata[VY_LO +: POSITION_BITS]});
		yaw_w = $signed({{(32-ANGLE_BITS){s_axis_tdata[YAW_LO+ANGLE_BITS-1]}},
			s_axis_tdata[YAW_LO +: ANGLE_BITS]});
		yaw_w = ((yaw_w <<< YAW_L) + YAW_RND) >>> YAW_R;
	end

	// normalize checks and rotator step
	always_comb begin
		mx       = x_q[CW-1] ? CW'(-x_q) : x_q;
		my       = y_q[CW-1] ? CW'(-y_q) : y_q;
		is_zero  = (x_q == '0) && (y_q == '0);
		both_lo  = (mx < NORM_LO) && (my < NORM_LO);
		both_hi  = (mx < NORM_HI) && (my < NORM_HI);
		xs       = x_q >>> iter_q;
		ys       = y_q >>> iter_q;
		tab_idx  = pps_pkg::TIW'(iter_q);
		tab      = $signed({{(ZW-16){1'b0}}, pps_pkg::ATAN_TAB[tab_idx]});
		// clockwise step: vectoring on y sign, rotation on angle sign
		cw       = (pass_q == pps_pkg::PASS_SINE) ? z_q[ZW-1] : !y_q[CW-1];
		last_iter = (iter_q == IW'(CORDIC_STEPS - 1));
	end

	// fold alpha into the right half plane for the sine pass
	always_comb begin
		if (z_q > pps_pkg::HALF_PI_Z) begin
			fold = pps_pkg::PI_Z - z_q;
		end else if (z_q < -pps_pkg::HALF_PI_Z) begin
			fold = -pps_pkg::PI_Z - z_q;
		end else begin
			fold = z_q;
		end
	end

	// sine rounding and saturation
	always_comb begin
		sv = (y_q + SIN_HALF) >>> 15;
		if (sv > SIN_MAX) begin
			s_n = pps_pkg::SIN_W'(SIN_MAX);
		end else if (sv < -SIN_MAX) begin
			s_n = pps_pkg::SIN_W'(-SIN_MAX);
		end else begin
			s_n = sv[pps_pkg::SIN_W-1:0];
		end
	end

	// steering rounding, clamp and negation
	always_comb begin
		stw  = (z_q + ZW'(4)) >>> 3;
		limz = $signed({{(ZW-pps_pkg::LIMIT_W){1'b0}}, lim_q});
		if (stw > limz) begin
			stc = limz;
		end else if (stw < -limz) begin
			stc = -limz;
		end else begin
			stc = stw;
		end
		stn = -stc;
	end

	// shared multiplier
	always_comb begin
		w_sat  = (sw_q > 16'd32768) ? 17'd32768 : {1'b0, sw_q};
		w_comp = 17'd32768 - w_sat;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			pps_pkg::ST_MULS: begin
				mul_a = $signed({1'b0, wb_q});
				mul_b = s_q;
			end
			pps_pkg::ST_MULW: begin
				mul_a = $signed({{(pps_pkg::MA_W-17){1'b0}}, w_sat});
				mul_b = $signed({{2{st_q[pps_pkg::STEER_W-1]}}, st_q});
			end
			pps_pkg::ST_MULL: begin
				mul_a = $signed({{(pps_pkg::MA_W-17){1'b0}}, w_comp});
				mul_b = $signed({{2{last_q[pps_pkg::STEER_W-1]}}, last_q});
			end
			default: ;
		endcase
		prod_n = mul_a * mul_b;
	end

	// blend rounding and saturation
	always_comb begin
		sum = acc_q + prod_q;
		rnd = (sum + RES_HALF) >>> 15;
		if (rnd > RES_MAX) begin
			res_n = pps_pkg::STEER_W'(RES_MAX);
		end else if (rnd < RES_MIN) begin
			res_n = pps_pkg::STEER_W'(RES_MIN);
		end else begin
			res_n = rnd[pps_pkg::STEER_W-1:0];
		end
	end

	// where an atan2 pass continues
	assign atan_done = (pass_q == pps_pkg::PASS_STEER) ? pps_pkg::ST_CLAMP : pps_pkg::ST_ALPHA;

	// sequencer
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			pps_pkg::ST_IDLE: begin
				if (in_take && both_present) begin
					state_n = pps_pkg::ST_NORM;
				end
			end
			pps_pkg::ST_NORM: begin
				if (is_zero) begin
					state_n = atan_done;
				end else if (!both_hi) begin
					state_n = pps_pkg::ST_ROT;
				end
			end
			pps_pkg::ST_ROT: begin
				if (last_iter) begin
					state_n = (pass_q == pps_pkg::PASS_SINE) ? pps_pkg::ST_SINOUT : atan_done;
				end
			end
			pps_pkg::ST_ALPHA:  state_n = pps_pkg::ST_WRAP;
			pps_pkg::ST_WRAP: begin
				if (!(z_q > pps_pkg::PI_Z) && !(z_q <= -pps_pkg::PI_Z)) begin
					state_n = pps_pkg::ST_ROT;
				end
			end
			pps_pkg::ST_SINOUT: state_n = pps_pkg::ST_MULS;
			pps_pkg::ST_MULS:   state_n = pps_pkg::ST_LOAD2;
			pps_pkg::ST_LOAD2:  state_n = pps_pkg::ST_NORM;
			pps_pkg::ST_CLAMP:  state_n = pps_pkg::ST_MULW;
			pps_pkg::ST_MULW:   state_n = pps_pkg::ST_MULL;
			pps_pkg::ST_MULL:   state_n = pps_pkg::ST_BLEND;
			pps_pkg::ST_BLEND: begin
				if (out_load) begin
					state_n = pps_pkg::ST_IDLE;
				end
			end
			default: state_n = pps_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pps_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			last_q      <= '0;
			la_q        <= pps_pkg::LA_RESET;
			wb_q        <= pps_pkg::WB_RESET;
			lim_q       <= pps_pkg::LIMIT_RESET;
			sw_q        <= pps_pkg::SW_RESET;
		end else begin
			state_q <= state_n;
			if (out_load) begin
				out_valid_q <= 1'b1;
				last_q      <= res_n;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (pps_pkg::reg_idx_t'(cfg_index))
					pps_pkg::REG_LOOKAHEAD:   la_q  <= cfg_data[pps_pkg::LA_W-1:0];
					pps_pkg::REG_WHEEL_BASE:  wb_q  <= cfg_data[pps_pkg::WB_W-1:0];
					pps_pkg::REG_STEER_LIMIT: lim_q <= cfg_data[pps_pkg::LIMIT_W-1:0];
					pps_pkg::REG_SMOOTHING:   sw_q  <= cfg_data[pps_pkg::SW_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			pps_pkg::ST_IDLE: begin
				x_q    <= dx;
				y_q    <= dy;
				yaw_q  <= yaw_w[ZW-1:0];
				pass_q <= pps_pkg::PASS_BEARING;
			end
			pps_pkg::ST_NORM: begin
				iter_q <= '0;
				if (is_zero) begin
					z_q <= '0;
				end else if (both_lo) begin
					x_q <= x_q <<< pps_pkg::NORM_COARSE;
					y_q <= y_q <<< pps_pkg::NORM_COARSE;
				end else if (both_hi) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end else if (x_q[CW-1] && !y_q[CW-1]) begin
					// left half plane, upper: rotate by minus a quarter turn
					x_q <= y_q;
					y_q <= -x_q;
					z_q <= pps_pkg::HALF_PI_Z;
				end else if (x_q[CW-1]) begin
					x_q <= -y_q;
					y_q <= x_q;
					z_q <= -pps_pkg::HALF_PI_Z;
				end else begin
					z_q <= '0;
				end
			end
			pps_pkg::ST_ROT: begin
				x_q    <= cw ? x_q + ys : x_q - ys;
				y_q    <= cw ? y_q - xs : y_q + xs;
				z_q    <= cw ? z_q + tab : z_q - tab;
				iter_q <= iter_q + IW'(1);
			end
			pps_pkg::ST_ALPHA: begin
				z_q <= z_q - yaw_q;
			end
			pps_pkg::ST_WRAP: begin
				if (z_q > pps_pkg::PI_Z) begin
					z_q <= z_q - pps_pkg::TWO_PI_Z;
				end else if (z_q <= -pps_pkg::PI_Z) begin
					z_q <= z_q + pps_pkg::TWO_PI_Z;
				end else begin
					x_q    <= GAIN_INV;
					y_q    <= '0;
					z_q    <= fold;
					iter_q <= '0;
					pass_q <= pps_pkg::PASS_SINE;
				end
			end
			pps_pkg::ST_SINOUT: begin
				s_q <= s_n;
			end
			pps_pkg::ST_MULS: begin
				prod_q <= prod_n;
			end
			pps_pkg::ST_LOAD2: begin
				// lookahead scaled to Q.31, numerator is twice wheel base times sine
				x_q    <= $signed({{(CW-pps_pkg::LA_W-15){1'b0}}, la_q, 15'b0});
				y_q    <= $signed({{(CW-PW-1){prod_q[PW-1]}}, prod_q, 1'b0});
				pass_q <= pps_pkg::PASS_STEER;
			end
			pps_pkg::ST_CLAMP: begin
				st_q <= stn[pps_pkg::STEER_W-1:0];
			end
			pps_pkg::ST_MULW: begin
				prod_q <= prod_n;
			end
			pps_pkg::ST_MULL: begin
				acc_q  <= prod_q;
				prod_q <= prod_n;
			end
			default: ;
		endcase
	end

	// a result only appears out of the blend step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == pps_pkg::ST_BLEND))
		else $error("result raised outside the blend step");

	// an item with pose or path missing leaves no trace
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && !both_present) |=> (state_q == pps_pkg::ST_IDLE) && $stable(last_q))
		else $error("item without pose or path changed the block");

	// last steering moves only when a result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		(last_q != $past(last_q)) |-> $past(out_load))
		else $error("last steering changed without a result");

	// a finished item holds in blend while the previous result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pps_pkg::ST_BLEND && m_axis_tvalid && !m_axis_tready)
		|=> state_q == pps_pkg::ST_BLEND)
		else $error("blend step overran a waiting result");

endmodule
